// ===== rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table: item kinds,
// datapath operation codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package dvrt_pkg;

	// Table geometry and register defaults
	localparam int          DEFAULT_MAX_NODES = 16;
	localparam logic [4:0]  ACTIVE_RESET      = 5'd16;

	// Distance encoding
	localparam logic [15:0] UNREACH = 16'hFFFF;
	localparam logic [15:0] SAT_MAX = 16'hFFFE;

	// Kind of an input request
	typedef enum logic [1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_INSTALL = 2'd1,
		KIND_RELAX   = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	// Datapath operation for the current cycle
	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_SWEEP   = 3'd1,
		OP_INST_AB = 3'd2,
		OP_INST_BA = 3'd3,
		OP_PASS1   = 3'd4,
		OP_PASS2   = 3'd5,
		OP_READ    = 3'd6,
		OP_LATCH   = 3'd7
	} dp_op_t;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   load;   // capture the accepted request
		logic   emit;   // move the result into the output register
	} dvrt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  link_ok;     // both ends in range and distinct
		logic  last_col;    // column counter is on the last active node
		logic  sweep_done;  // clearing sweep is on its last address
		logic  out_busy;    // output register holds a result not taken now
	} dvrt_status_t;

endpackage

// ===== rtl/dvrt_ram.sv =====
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

// ===== rtl/dvrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Request sequencer: decodes each request and steps the datapath through
// the clearing sweep, link install, the two relax passes or a table read.
// ----------------------------------------------------------------------------
module dvrt_ctrl
	import dvrt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  dvrt_status_t status,
	output dvrt_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_INST1,
		ST_INST2,
		ST_P1,
		ST_P1_DRAIN,
		ST_P2,
		ST_P2_DRAIN,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Hold state, advance on status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (status.sweep_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					case (status.kind)
						KIND_CLEAR:   state_q <= ST_SWEEP;
						KIND_INSTALL: state_q <= status.link_ok ? ST_INST1 : ST_FINISH;
						KIND_RELAX:   state_q <= status.link_ok ? ST_P1 : ST_FINISH;
						KIND_READ:    state_q <= ST_RD_ADDR;
						default:      state_q <= ST_FINISH;
					endcase
				end
				ST_SWEEP: begin
					if (status.sweep_done) state_q <= ST_FINISH;
				end
				ST_INST1:    state_q <= ST_INST2;
				ST_INST2:    state_q <= ST_FINISH;
				ST_P1: begin
					if (status.last_col) state_q <= ST_P1_DRAIN;
				end
				ST_P1_DRAIN: state_q <= ST_P2;
				ST_P2: begin
					if (status.last_col) state_q <= ST_P2_DRAIN;
				end
				ST_P2_DRAIN: state_q <= ST_FINISH;
				ST_RD_ADDR:  state_q <= ST_RD_DATA;
				ST_RD_DATA:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!status.out_busy) state_q <= ST_IDLE;
				end
				default:     state_q <= ST_INIT;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Drive datapath commands from state
	always_comb begin
		cmd.op   = OP_NONE;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		case (state_q)
			ST_INIT:    cmd.op = OP_SWEEP;
			ST_IDLE:    cmd.load = s_tvalid;
			ST_SWEEP:   cmd.op = OP_SWEEP;
			ST_INST1:   cmd.op = OP_INST_AB;
			ST_INST2:   cmd.op = OP_INST_BA;
			ST_P1:      cmd.op = OP_PASS1;
			ST_P2:      cmd.op = OP_PASS2;
			ST_RD_ADDR: cmd.op = OP_READ;
			ST_RD_DATA: cmd.op = OP_LATCH;
			ST_FINISH:  cmd.emit = !status.out_busy;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/dvrt_datapath.sv =====
// ----------------------------------------------------------------------------
// dvrt_datapath
// Route table storage and arithmetic: request capture, node count, column
// and sweep counters, the relax compare/update stage, the read result and
// the output register.
// ----------------------------------------------------------------------------
module dvrt_datapath
	import dvrt_pkg::*;
#(
	parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dvrt_cmd_t    cmd,
	output dvrt_status_t status,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_active,
	input  logic [1:0]   in_kind,
	input  logic [3:0]   in_a,
	input  logic [3:0]   in_b,
	input  logic [11:0]  in_w,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         out_changed,
	output logic         out_reachable,
	output logic [15:0]  out_cost,
	output logic [3:0]   out_hop
);

	localparam int CW     = $clog2(MAX_NODES);
	localparam int RW     = CW;
	localparam int AW     = RW + CW;
	localparam int DEPTH  = MAX_NODES * (2 ** CW);
	localparam int CNTW   = $clog2(MAX_NODES + 1);
	localparam int WORD_W = 16 + RW;

	// Captured request
	kind_t       kind_q;
	logic [3:0]  a_q;
	logic [3:0]  b_q;
	logic [11:0] w_q;
	logic [4:0]  active_q;

	logic [CNTW-1:0] eff_nodes;
	logic            in_range;
	logic [RW-1:0]   row_a;
	logic [RW-1:0]   row_b;

	// Counters and relax stage
	logic [CW-1:0] col_q;
	logic [AW-1:0] sweep_q;
	logic          vld_s1;
	logic          pass2_s1;
	logic [CW-1:0] col_s1;
	logic          changed_q;

	// Read result
	logic [15:0] rd_dist_q;
	logic [3:0]  rd_hop_q;

	// RAM ports
	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic [AW-1:0]     raddr0;
	logic [AW-1:0]     raddr1;
	logic [WORD_W-1:0] rdata0;
	logic [WORD_W-1:0] rdata1;

	// Relax compare
	logic [15:0]   dist_a;
	logic [15:0]   dist_b;
	logic [RW-1:0] hop_b;
	logic [15:0]   src_dist;
	logic [15:0]   dst_dist;
	logic [16:0]   sum;
	logic [15:0]   new_dist;
	logic          skip;
	logic          better;
	logic          tie_lower;

	function automatic logic offered(input logic [15:0] d);
		return (d != 16'd0) && (d != UNREACH);
	endfunction

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_active;
		end
	end

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(in_kind);
			a_q    <= in_a;
			b_q    <= in_b;
			w_q    <= in_w;
		end
	end

	// Effective node count and range checks
	always_comb begin
		if (32'(active_q) > MAX_NODES) begin
			eff_nodes = CNTW'(MAX_NODES);
		end else begin
			eff_nodes = CNTW'(active_q);
		end
		in_range = (32'(a_q) < 32'(eff_nodes)) && (32'(b_q) < 32'(eff_nodes));
		row_a    = RW'(a_q);
		row_b    = RW'(b_q);
	end

	assign status.kind       = kind_q;
	assign status.link_ok    = in_range && (a_q != b_q);
	assign status.last_col   = (32'(col_q) == (32'(eff_nodes) - 32'd1));
	assign status.sweep_done = (sweep_q == AW'(DEPTH - 1));
	assign status.out_busy   = out_valid && !out_ready;

	// Advance column and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			sweep_q  <= '0;
			vld_s1   <= 1'b0;
			pass2_s1 <= 1'b0;
		end else begin
			if ((cmd.op == OP_PASS1) || (cmd.op == OP_PASS2)) begin
				col_q <= status.last_col ? '0 : col_q + CW'(1);
			end else begin
				col_q <= '0;
			end
			if ((cmd.op == OP_SWEEP) && !status.sweep_done) begin
				sweep_q <= sweep_q + AW'(1);
			end else begin
				sweep_q <= '0;
			end
			vld_s1   <= (cmd.op == OP_PASS1) || (cmd.op == OP_PASS2);
			pass2_s1 <= (cmd.op == OP_PASS2);
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q;
	end

	// Read addresses: port 0 walks row a, port 1 walks row b
	always_comb begin
		if (cmd.op == OP_READ) begin
			raddr0 = {row_a, CW'(b_q)};
		end else begin
			raddr0 = {row_a, col_q};
		end
		raddr1 = {row_b, col_q};
	end

	// Offer one destination: pass 1 pushes a into b, pass 2 pushes b into a
	always_comb begin
		dist_a    = rdata0[WORD_W-1:RW];
		dist_b    = rdata1[WORD_W-1:RW];
		hop_b     = rdata1[RW-1:0];
		src_dist  = pass2_s1 ? dist_b : dist_a;
		dst_dist  = pass2_s1 ? dist_a : dist_b;
		sum       = 17'(w_q) + 17'(src_dist);
		new_dist  = (sum > 17'(SAT_MAX)) ? SAT_MAX : sum[15:0];
		skip      = (col_s1 == CW'(a_q)) || (col_s1 == CW'(b_q)) || !offered(src_dist);
		better    = vld_s1 && !skip && ((dst_dist == UNREACH) || (dst_dist > new_dist));
		tie_lower = vld_s1 && !skip && !pass2_s1 && (dst_dist == new_dist) &&
			(hop_b > row_a);
	end

	// Table write port
	always_comb begin
		we    = 1'b0;
		waddr = sweep_q;
		wdata = {UNREACH, RW'(0)};
		if (vld_s1) begin
			we = better || tie_lower;
			if (pass2_s1) begin
				waddr = {row_a, col_s1};
				wdata = {new_dist, row_b};
			end else begin
				waddr = {row_b, col_s1};
				wdata = {(better ? new_dist : dist_b), row_a};
			end
		end else begin
			case (cmd.op)
				OP_SWEEP: begin
					we    = 1'b1;
					waddr = sweep_q;
					if (sweep_q[AW-1:CW] == sweep_q[CW-1:0]) begin
						wdata = {16'd0, sweep_q[AW-1:CW]};
					end else begin
						wdata = {UNREACH, RW'(0)};
					end
				end
				OP_INST_AB: begin
					we    = 1'b1;
					waddr = {row_a, CW'(b_q)};
					wdata = {16'(w_q), row_b};
				end
				OP_INST_BA: begin
					we    = 1'b1;
					waddr = {row_b, CW'(a_q)};
					wdata = {16'(w_q), row_a};
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	dvrt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	// Track whether the relax improved anything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (cmd.load) begin
			changed_q <= 1'b0;
		end else if (better) begin
			changed_q <= 1'b1;
		end
	end

	// Hold the read entry; an out-of-range node reads as unreachable
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			rd_dist_q <= in_range ? dist_a : UNREACH;
			rd_hop_q  <= 4'(rdata0[RW-1:0]);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_changed <= changed_q && (kind_q == KIND_RELAX);
			if (kind_q == KIND_READ) begin
				out_reachable <= (rd_dist_q != UNREACH);
				out_cost      <= rd_dist_q;
				out_hop       <= (rd_dist_q != UNREACH) ? rd_hop_q : 4'd0;
			end else begin
				out_reachable <= 1'b0;
				out_cost      <= 16'd0;
				out_hop       <= 4'd0;
			end
		end
	end

	// Pass 1 only updates row b
	a_pass1_row: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !pass2_s1 && we) |-> (waddr[AW-1:CW] == row_b))
		else $error("pass 1 write outside row b");

	// Pass 2 only updates row a
	a_pass2_row: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && pass2_s1 && we) |-> (waddr[AW-1:CW] == row_a))
		else $error("pass 2 write outside row a");

	// A result never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && !out_ready))
		else $error("result emitted over a pending result");

	// Only a relax reports a change
	a_changed_relax: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (kind_q != KIND_RELAX)) |=> !out_changed)
		else $error("changed set for a non-relax request");

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Per-node distance-vector routing tables with clear, link install, relax
// across one link and entry read.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  s_*     | in  | s_tvalid / s_tready       | tuser kind; tdata node_a, node_b, weight
//  m_*     | out | m_tvalid / m_tready       | tdata changed, reachable, route_cost, next_hop
//  cfg_*   | in  | cfg_valid / cfg_ready     | cfg_data active_nodes
//
//  Per request, N = effective node count: relax makes two passes over N destinations of the
//  table RAM (one destination a cycle), clear writes MAX_NODES*2^ceil(log2(MAX_NODES)) RAM
//  words (one RAM word a cycle), install writes both entries, read addresses then latches
//  the entry, and a rejected install or relax goes straight to its result. One request is in
//  work at a time; after reset the clearing sweep runs with s_tready low. A stalled result
//  holds the next request in its last step; configuration writes are always taken.
// ----------------------------------------------------------------------------
module distance_vector_route_table
	import dvrt_pkg::*;
#(
	parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] node_a, [7:4] node_b, [19:8] weight, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] changed, [1] reachable, [17:2] route_cost,
	                               // [21:18] next_hop, rest zero
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // [4:0] active_nodes
);

	dvrt_cmd_t    cmd;
	dvrt_status_t status;

	logic        out_changed;
	logic        out_reachable;
	logic [15:0] out_cost;
	logic [3:0]  out_hop;

	assign cfg_ready = 1'b1;

	dvrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dvrt_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid),
		.cfg_active    (cfg_data),
		.in_kind       (s_tuser),
		.in_a          (s_tdata[3:0]),
		.in_b          (s_tdata[7:4]),
		.in_w          (s_tdata[19:8]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_changed   (out_changed),
		.out_reachable (out_reachable),
		.out_cost      (out_cost),
		.out_hop       (out_hop)
	);

	// Pack the result
	assign m_tdata = {2'b00, out_hop, out_cost, out_reachable, out_changed};

endmodule

// ===== sim/dvrt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvrt_checker
// Watches the request, result and configuration channels of the route table.
// It keeps its own copy of the distance and next-hop tables, works out the
// result of every accepted request, and compares each result the block
// returns with the oldest result still outstanding.
// ----------------------------------------------------------------------------
module dvrt_checker
	import dvrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] node_a, [7:4] node_b, [19:8] weight, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [0] changed, [1] reachable, [17:2] route_cost,
	                               // [21:18] next_hop, rest zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,  // [4:0] active_nodes
	output int          errors,
	output int          outstanding
);

	localparam int NODES = DEFAULT_MAX_NODES;

	typedef struct packed {
		logic        changed;
		logic        reachable;
		logic [15:0] route_cost;
		logic [3:0]  next_hop;
	} route_result_t;

	logic [15:0]   dist_tbl [NODES][NODES];
	logic [3:0]    hop_tbl  [NODES][NODES];
	logic [4:0]    active_nodes_q;
	route_result_t expected_routes [$];

	// Put every row back to a route to itself only
	function automatic void reset_tables();
		for (int r = 0; r < NODES; r++) begin
			for (int c = 0; c < NODES; c++) begin
				dist_tbl[r][c] = (r == c) ? 16'd0 : UNREACH;
				hop_tbl[r][c]  = (r == c) ? 4'(r) : 4'd0;
			end
		end
	endfunction

	function automatic int unsigned node_limit();
		return (active_nodes_q > NODES) ? NODES : active_nodes_q;
	endfunction

	// Link cost plus distance, clamped below the unreachable code
	function automatic logic [15:0] path_cost(int unsigned w, int unsigned d);
		int unsigned sum;
		sum = w + d;
		return (sum > SAT_MAX) ? SAT_MAX : 16'(sum);
	endfunction

	function automatic bit usable(logic [15:0] d);
		return d != 16'd0 && d != UNREACH;
	endfunction

	// One exchange across link a-b: a's routes into b, then b's into a
	function automatic bit exchange_routes(int unsigned a, int unsigned b,
		int unsigned w, int unsigned n);
		bit          moved;
		logic [15:0] cand;
		moved = 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			if (i == a || i == b)
				continue;
			if (!usable(dist_tbl[a][i]))
				continue;
			cand = path_cost(w, dist_tbl[a][i]);
			// equal cost only pulls the next hop down toward a
			if (dist_tbl[b][i] == cand && hop_tbl[b][i] > a)
				hop_tbl[b][i] = 4'(a);
			if (dist_tbl[b][i] == UNREACH || dist_tbl[b][i] > cand) begin
				dist_tbl[b][i] = cand;
				hop_tbl[b][i]  = 4'(a);
				moved = 1'b1;
			end
		end
		for (int unsigned i = 0; i < n; i++) begin
			if (i == a || i == b)
				continue;
			if (!usable(dist_tbl[b][i]))
				continue;
			cand = path_cost(w, dist_tbl[b][i]);
			if (dist_tbl[a][i] == UNREACH || dist_tbl[a][i] > cand) begin
				dist_tbl[a][i] = cand;
				hop_tbl[a][i]  = 4'(b);
				moved = 1'b1;
			end
		end
		return moved;
	endfunction

	// Update the tables for one request and return its result
	function automatic route_result_t apply_request(kind_t kind, int unsigned a,
		int unsigned b, int unsigned w);
		route_result_t r;
		int unsigned   n;
		bit            in_range;
		r = '0;
		n = node_limit();
		in_range = a < n && b < n;
		case (kind)
			KIND_CLEAR: begin
				reset_tables();
			end
			KIND_INSTALL: begin
				if (in_range && a != b) begin
					dist_tbl[a][b] = 16'(w);
					hop_tbl[a][b]  = 4'(b);
					dist_tbl[b][a] = 16'(w);
					hop_tbl[b][a]  = 4'(a);
				end
			end
			KIND_RELAX: begin
				if (in_range && a != b)
					r.changed = exchange_routes(a, b, w, n);
			end
			default: begin
				r.route_cost = in_range ? dist_tbl[a][b] : UNREACH;
				r.next_hop   = in_range ? hop_tbl[a][b] : 4'd0;
				if (r.route_cost == UNREACH)
					r.next_hop = 4'd0;
				r.reachable = r.route_cost != UNREACH;
			end
		endcase
		return r;
	endfunction

	function automatic void report_result(string what, route_result_t want,
		route_result_t got);
		errors++;
		if (errors <= 10) begin
			$display("%0t %s: expected changed=%0d reachable=%0d cost=%0d hop=%0d",
				$time, what, want.changed, want.reachable, want.route_cost,
				want.next_hop);
			$display("%0t %s: got changed=%0d reachable=%0d cost=%0d hop=%0d",
				$time, what, got.changed, got.reachable, got.route_cost,
				got.next_hop);
		end
	endfunction

	// Retire results first, then take a new request into the tables
	always @(posedge clk or negedge arst_n) begin
		route_result_t got;
		route_result_t want;
		if (!arst_n) begin
			reset_tables();
			active_nodes_q = ACTIVE_RESET;
			expected_routes.delete();
			errors      = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[1], m_tdata[17:2], m_tdata[21:18]};
				if (expected_routes.size() == 0) begin
					report_result("result with no request outstanding", '0, got);
				end else begin
					want = expected_routes.pop_front();
					if (got !== want || m_tdata[23:22] !== 2'b00)
						report_result("route result mismatch", want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				active_nodes_q = cfg_data;
			if (s_tvalid && s_tready)
				expected_routes.insert(expected_routes.size(),
					apply_request(kind_t'(s_tuser), s_tdata[3:0], s_tdata[7:4],
					s_tdata[19:8]));
			outstanding = expected_routes.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the route table with a directed opening (self entries, links, ties,
// zero-weight links, a long chain of exchanges) and then random requests over
// several node counts, with bursty requests and a stalling result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import dvrt_pkg::*;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [3:0] node_a, [7:4] node_b, [19:8] weight, rest zero
	logic [1:0]  s_tuser   = '0;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [0] changed, [1] reachable, [17:2] route_cost,
	                               // [21:18] next_hop, rest zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data  = '0;   // [4:0] active_nodes
	int          errors;
	int          outstanding;
	int unsigned active_now = ACTIVE_RESET;

	distance_vector_route_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dvrt_checker u_route_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: ready runs, short stalls, long stalls and toggling
	initial begin
		int unsigned len;
		forever begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					len = $urandom_range(1, 30);
					repeat (len) begin
						m_tready <= 1'b1;
						@(posedge clk);
					end
				end
				4, 5, 6: begin
					len = $urandom_range(1, 3);
					repeat (len) begin
						m_tready <= 1'b0;
						@(posedge clk);
					end
				end
				7: begin
					len = $urandom_range(10, 40);
					repeat (len) begin
						m_tready <= 1'b0;
						@(posedge clk);
					end
				end
				default: begin
					len = $urandom_range(1, 20);
					repeat (len) begin
						m_tready <= ~m_tready;
						@(posedge clk);
					end
				end
			endcase
		end
	end

	// Present one request and hold it until accepted
	task automatic send_request(kind_t kind, logic [3:0] a, logic [3:0] b,
		logic [11:0] w);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0000, w, b, a};
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every request has its result and the block has gone quiet
	task automatic drain_results(int unsigned quiet);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (quiet) @(posedge clk);
	endtask

	task automatic write_active(logic [4:0] value);
		drain_results(8);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_now = value;
	endtask

	// Mostly nodes in use, now and then any node
	function automatic logic [3:0] pick_node(int unsigned n);
		if (n == 0 || $urandom_range(0, 9) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, n - 1));
	endfunction

	task automatic run_phase(int unsigned count);
		int unsigned n;
		int unsigned pick;
		int unsigned burst;
		bit          steady;
		kind_t       kind;
		logic [3:0]  a;
		logic [3:0]  b;
		logic [11:0] w;
		n      = (active_now > DEFAULT_MAX_NODES) ? DEFAULT_MAX_NODES : active_now;
		steady = ($urandom_range(0, 3) == 0);
		burst  = $urandom_range(1, 20);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				kind = KIND_CLEAR;
			else if (pick < 28)
				kind = KIND_INSTALL;
			else if (pick < 68)
				kind = KIND_RELAX;
			else
				kind = KIND_READ;
			a = pick_node(n);
			b = pick_node(n);
			// small weights make equal-cost routes common
			pick = $urandom_range(0, 99);
			if (pick < 55)
				w = 12'($urandom_range(1, 8));
			else if (pick < 75)
				w = 12'($urandom_range(1, 4095));
			else if (pick < 85)
				w = 12'd4095;
			else if (pick < 90)
				w = 12'd0;
			else
				w = 12'($urandom_range(3800, 4095));
			send_request(kind, a, b, w);
			// at the end of each burst, unless the phase is steady, sometimes insert a gap
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if (!steady) begin
					pick = $urandom_range(0, 6);
					if (pick != 0) begin
						s_tvalid <= 1'b0;
						repeat (pick) @(posedge clk);
					end
				end
			end
		end
	endtask

	task automatic run_directed();
		// self entry and an empty entry
		send_request(KIND_READ, 4'd0, 4'd0, 12'd0);
		send_request(KIND_READ, 4'd15, 4'd3, 12'hFFF);
		send_request(KIND_INSTALL, 4'd3, 4'd3, 12'd5);
		// equal cost through node 8 only moves the next hop
		send_request(KIND_INSTALL, 4'd9, 4'd10, 12'd6);
		send_request(KIND_INSTALL, 4'd8, 4'd10, 12'd3);
		send_request(KIND_RELAX, 4'd8, 4'd9, 12'd3);
		send_request(KIND_READ, 4'd9, 4'd10, 12'd0);
		// a zero-distance entry is never offered
		send_request(KIND_INSTALL, 4'd2, 4'd4, 12'd0);
		send_request(KIND_RELAX, 4'd4, 4'd5, 12'd9);
		send_request(KIND_READ, 4'd5, 4'd2, 12'd0);
		send_request(KIND_CLEAR, 4'd15, 4'd15, 12'hFFF);
		// long chain of heavy links toward node 0
		send_request(KIND_INSTALL, 4'd0, 4'd1, 12'd4095);
		for (int i = 1; i < 14; i++)
			send_request(KIND_RELAX, 4'(i), 4'(i + 1), 12'd4095);
		send_request(KIND_READ, 4'd14, 4'd0, 12'd0);
		send_request(KIND_READ, 4'd0, 4'd14, 12'd0);
	endtask

	// Stimulus and verdict
	initial begin
		logic [4:0] settings [8];
		settings = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2, 5'd20, 5'd11};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(150);
		foreach (settings[i]) begin
			write_active(settings[i]);
			run_phase(settings[i] < 2 ? 60 : 220);
		end
		write_active(5'($urandom_range(0, 31)));
		run_phase(150);
		drain_results(50);
		if (errors == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dvrt_pkg.sv
rtl/dvrt_ram.sv
rtl/dvrt_ctrl.sv
rtl/dvrt_datapath.sv
rtl/distance_vector_route_table.sv
sim/dvrt_checker.sv
sim/tb_top.sv
